// ===== rtl/core/mcr_pkg.sv =====
package mcr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 9;

  // Offsets are held signed so that a zero radius can step to y = -1.
  localparam int OFS_W  = RADIUS_BITS + 1;
  localparam int DEC_W  = RADIUS_BITS + 5;
  localparam int PT_W   = 12;
  localparam int CALC_W = COORD_BITS + OFS_W + 1;
  localparam int IDX_W  = 4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(15);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [DEC_W-1:0] DEC_INIT   = DEC_W'(3);
  localparam logic [DEC_W-1:0] DEC_DIAG   = DEC_W'(10);
  localparam logic [DEC_W-1:0] DEC_STRAIT = DEC_W'(6);

  // Snapshot of one step: the two offset pairs to be mirrored, or a finished marker.
  typedef struct packed {
    logic                    done;
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;
    logic signed [OFS_W-1:0] x0;
    logic signed [OFS_W-1:0] y0;
    logic signed [OFS_W-1:0] x1;
    logic signed [OFS_W-1:0] y1;
  } job_t;

endpackage

// ===== rtl/core/mcr_stepper.sv =====
module mcr_stepper import mcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   opcode,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output job_t                   job
);

  logic [COORD_BITS-1:0]   stored_cx;
  logic [COORD_BITS-1:0]   stored_cy;
  logic signed [OFS_W-1:0] offset_x;
  logic signed [OFS_W-1:0] offset_y;
  logic signed [DEC_W-1:0] decision;
  logic                    running;

  logic                    finished;
  logic signed [OFS_W-1:0] x_next;
  logic signed [OFS_W-1:0] y_next;
  logic signed [OFS_W:0]   diff;
  logic signed [DEC_W-1:0] decision_next;

  always_comb begin
    finished = !running || (offset_y < offset_x);
    x_next   = offset_x + OFS_W'(1);
    if (decision > 0) begin
      y_next        = offset_y - OFS_W'(1);
      diff          = (OFS_W + 1)'(x_next) - (OFS_W + 1)'(y_next);
      decision_next = decision + (DEC_W'(diff) <<< 2) + signed'(DEC_DIAG);
    end else begin
      y_next        = offset_y;
      diff          = '0;
      decision_next = decision + (DEC_W'(x_next) <<< 2) + signed'(DEC_STRAIT);
    end
  end

  assign job.done = finished;
  assign job.cx   = stored_cx;
  assign job.cy   = stored_cy;
  assign job.x0   = offset_x;
  assign job.y0   = offset_y;
  assign job.x1   = x_next;
  assign job.y1   = y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_cx <= '0;
      stored_cy <= '0;
      offset_x  <= '0;
      offset_y  <= '0;
      decision  <= '0;
      running   <= 1'b0;
    end else if (accept) begin
      if (opcode == OP_START) begin
        stored_cx <= center_x;
        stored_cy <= center_y;
        offset_x  <= '0;
        offset_y  <= signed'(OFS_W'(radius));
        decision  <= signed'(DEC_INIT - (DEC_W'(radius) << 1));
        running   <= 1'b1;
      end else if (finished) begin
        running <= 1'b0;
      end else begin
        offset_x <= x_next;
        offset_y <= y_next;
        decision <= decision_next;
      end
    end
  end

endmodule

// ===== rtl/core/mcr_emitter.sv =====
module mcr_emitter import mcr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_load,
  input  job_t            job_in,
  output logic            busy,
  output logic            finishing,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [PT_W-1:0] point_x,
  output logic [PT_W-1:0] point_y,
  output logic            last,
  output logic            done_res
);

  job_t             job;
  logic [IDX_W-1:0] idx;

  logic                     load_out;
  logic                     final_pt;
  logic signed [OFS_W-1:0]  a;
  logic signed [OFS_W-1:0]  b;
  logic signed [OFS_W-1:0]  u;
  logic signed [OFS_W-1:0]  v;
  logic signed [CALC_W-1:0] cxw;
  logic signed [CALC_W-1:0] cyw;
  logic signed [CALC_W-1:0] px;
  logic signed [CALC_W-1:0] py;

  always_comb begin
    load_out  = busy && (!result_valid || result_ready);
    final_pt  = job.done || (idx == LAST_IDX);
    finishing = load_out && final_pt;

    // The top index bit picks the pair before or after the move, the next one
    // swaps the roles of x and y, and the two low bits give the signs.
    a   = idx[3] ? job.x1 : job.x0;
    b   = idx[3] ? job.y1 : job.y0;
    u   = idx[2] ? b : a;
    v   = idx[2] ? a : b;
    cxw = signed'(CALC_W'(job.cx));
    cyw = signed'(CALC_W'(job.cy));
    px  = idx[0] ? cxw - CALC_W'(u) : cxw + CALC_W'(u);
    py  = idx[1] ? cyw - CALC_W'(v) : cyw + CALC_W'(v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (job_load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (finishing) begin
      busy <= 1'b0;
    end else if (load_out) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      point_x  <= job.done ? '0 : px[PT_W-1:0];
      point_y  <= job.done ? '0 : py[PT_W-1:0];
      last     <= final_pt;
      done_res <= job.done;
    end
  end

endmodule

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer.
// Items arrive on the item channel (item_valid / item_ready) carrying an opcode
// and, for a start, the centre and radius. A start transaction loads a new
// circle and produces no result; it is taken at any time, even while points of
// an earlier step are still being sent. A step transaction produces sixteen
// points, the eight mirrored points before and after one move of the offsets,
// with last set on the sixteenth; once the circle is finished a step produces a
// single result with done_res and last set and zero coordinates.
// Results leave on the result channel (result_valid / result_ready) from an
// output register, one per cycle while result_ready is high. The emitter copies
// the job when it takes the step transaction, and the first result of the step
// is registered from that copy. A step gives sixteen results, one for a
// finished circle, counted by the per-point counter of the emitter; the next
// step is taken in the cycle the last point is loaded.
// A stall on the result channel holds the result and the point counter; while a
// step is still being emitted, the item channel takes only start transactions.
// Synchronous reset clears the circle state to idle and empties the emitter.
module midpoint_circle_rasterizer import mcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   opcode,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [PT_W-1:0]        point_x,
  output logic [PT_W-1:0]        point_y,
  output logic                   last,
  output logic                   done_res
);

  job_t job;
  logic accept;
  logic busy;
  logic finishing;

  assign item_ready = !busy || finishing || (opcode == OP_START);
  assign accept     = item_valid && item_ready;

  mcr_stepper u_stepper (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (opcode),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .job      (job)
  );

  mcr_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .job_load     (accept && (opcode == OP_STEP)),
    .job_in       (job),
    .busy         (busy),
    .finishing    (finishing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last         (last),
    .done_res     (done_res)
  );

endmodule

// ===== sim/circle_point_checker.sv =====
`timescale 1ns / 100ps

module circle_point_checker import mcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  logic                   opcode,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  logic [PT_W-1:0]        point_x,
  input  logic [PT_W-1:0]        point_y,
  input  logic                   last,
  input  logic                   done_res,
  input  logic                   drain_check,
  output int                     fail_count,
  output int                     pending,
  output int                     points_checked,
  output int                     done_markers
);

  typedef struct packed {
    logic [PT_W-1:0] px;
    logic [PT_W-1:0] py;
    logic            last;
    logic            done;
  } point_t;

  point_t expected_points[$];
  point_t want;

  // Own copy of the circle state.
  logic [COORD_BITS-1:0]   circ_cx;
  logic [COORD_BITS-1:0]   circ_cy;
  logic signed [OFS_W-1:0] ofs_x;
  logic signed [OFS_W-1:0] ofs_y;
  logic signed [DEC_W-1:0] decision;
  logic                    running;

  int  errors = 0;
  int  checked = 0;
  int  markers = 0;
  bit  drained = 1'b0;

  function automatic void check_field(string name, logic [PT_W-1:0] want_v,
                                      logic [PT_W-1:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch on result %0d, expected %0d, got %0d",
               $time, name, checked, $signed(want_v), $signed(got_v));
    end
  endfunction

  // Queues the eight mirrored points of offset pair (a, b) about the stored centre.
  task automatic push_octants(logic signed [OFS_W-1:0] a, logic signed [OFS_W-1:0] b,
                              logic tail);
    int     cx;
    int     cy;
    int     ia;
    int     ib;
    int     xs[8];
    int     ys[8];
    point_t pt;
    cx = int'(circ_cx);
    cy = int'(circ_cy);
    ia = int'(a);
    ib = int'(b);
    xs = '{cx + ia, cx - ia, cx + ia, cx - ia, cx + ib, cx - ib, cx + ib, cx - ib};
    ys = '{cy + ib, cy + ib, cy - ib, cy - ib, cy + ia, cy + ia, cy - ia, cy - ia};
    for (int k = 0; k < 8; k++) begin
      pt.px   = xs[k][PT_W-1:0];
      pt.py   = ys[k][PT_W-1:0];
      pt.last = tail && (k == 7);
      pt.done = 1'b0;
      expected_points.push_back(pt);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_points.delete();
      circ_cx  = '0;
      circ_cy  = '0;
      ofs_x    = '0;
      ofs_y    = '0;
      decision = '0;
      running  = 1'b0;
    end else begin
      // Results are checked before the item of the same edge is predicted, as
      // a result never belongs to a transaction taken at the same edge.
      if (result_valid && result_ready) begin
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got x=%0d y=%0d last=%0b done=%0b",
                   $time, $signed(point_x), $signed(point_y), last, done_res);
        end else begin
          want = expected_points.pop_front();
          check_field("point_x", want.px, point_x);
          check_field("point_y", want.py, point_y);
          check_field("last", PT_W'(want.last), PT_W'(last));
          check_field("done_res", PT_W'(want.done), PT_W'(done_res));
          checked++;
          if (want.done) markers++;
        end
      end

      if (item_valid && item_ready) begin
        if (opcode == OP_START) begin
          circ_cx  = center_x;
          circ_cy  = center_y;
          ofs_x    = '0;
          ofs_y    = $signed({1'b0, radius});
          decision = DEC_W'(3 - 2 * int'(radius));
          running  = 1'b1;
        end else if (!running || ofs_y < ofs_x) begin
          running = 1'b0;
          want    = '{px: '0, py: '0, last: 1'b1, done: 1'b1};
          expected_points.push_back(want);
        end else begin
          push_octants(ofs_x, ofs_y, 1'b0);
          ofs_x = ofs_x + OFS_W'(1);
          if (decision > 0) begin
            ofs_y    = ofs_y - OFS_W'(1);
            decision = DEC_W'(int'(decision) + 4 * (int'(ofs_x) - int'(ofs_y)) + 10);
          end else begin
            decision = DEC_W'(int'(decision) + 4 * int'(ofs_x) + 6);
          end
          push_octants(ofs_x, ofs_y, 1'b1);
        end
      end

      if (drain_check && !drained) begin
        drained = 1'b1;
        if (expected_points.size() != 0) begin
          $display("%0t: %0d expected results never arrived, expected none left, got %0d",
                   $time, expected_points.size(), expected_points.size());
          errors += expected_points.size();
        end
      end
    end

    fail_count     <= errors;
    pending        <= expected_points.size();
    points_checked <= checked;
    done_markers   <= markers;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mcr_pkg::*;

  localparam int RANDOM_ITEMS = 128;
  localparam int HOLD_CYCLES  = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  logic                   opcode = OP_START;
  logic [COORD_BITS-1:0]  center_x = '0;
  logic [COORD_BITS-1:0]  center_y = '0;
  logic [RADIUS_BITS-1:0] radius = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [PT_W-1:0]        point_x;
  logic [PT_W-1:0]        point_y;
  logic                   last;
  logic                   done_res;
  logic                   drain_check = 1'b0;
  logic                   squeeze_start = 1'b0;
  logic                   hold_off = 1'b0;

  int fail_count;
  int pending;
  int points_checked;
  int done_markers;

  int sent = 0;
  int starts = 0;
  bit sender_calm = 1'b0;

  always #4 clk = ~clk;

  midpoint_circle_rasterizer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last         (last),
    .done_res     (done_res)
  );

  circle_point_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .opcode         (opcode),
    .center_x       (center_x),
    .center_y       (center_y),
    .radius         (radius),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .point_x        (point_x),
    .point_y        (point_y),
    .last           (last),
    .done_res       (done_res),
    .drain_check    (drain_check),
    .fail_count     (fail_count),
    .pending        (pending),
    .points_checked (points_checked),
    .done_markers   (done_markers)
  );

  // Mostly short pauses, now and then a long one.
  function automatic int idle_cycles();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int send_gap();
    if (sender_calm || $urandom_range(0, 1) == 0) return 0;
    return idle_cycles();
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(logic op, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                           logic [RADIUS_BITS-1:0] rad, int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    center_x   <= cx;
    center_y   <= cy;
    radius     <= rad;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
    if (op == OP_START) starts++;
  endtask

  initial begin : result_sink
    int stall_left;
    int mode_left;
    bit calm;
    stall_left = 0;
    mode_left  = 0;
    calm       = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 200);
      end
      mode_left--;
      if (hold_off) begin
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
    end
  end

  // Long hold-off on the result side, timed here and not by the sender.
  initial begin : result_hold
    wait (squeeze_start);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    int                     target;
    int                     nsteps;
    int                     choice;
    int                     waited;
    logic [RADIUS_BITS-1:0] rad;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Step on an idle block, with every field at its top value.
    send_item(OP_STEP, 10'd1023, 10'd1023, 9'd511, send_gap());
    // Zero radius at the origin: points of (0,0), then of (1,-1), then finished.
    send_item(OP_START, 10'd0, 10'd0, 9'd0, send_gap());
    repeat (3) send_item(OP_STEP, 10'd0, 10'd0, 9'd0, send_gap());
    // Largest radius at both corners, coordinates running off screen.
    send_item(OP_START, 10'd1023, 10'd1023, 9'd511, send_gap());
    repeat (2) send_item(OP_STEP, 10'd0, 10'd0, 9'd0, send_gap());
    send_item(OP_START, 10'd0, 10'd0, 9'd511, send_gap());
    send_item(OP_STEP, 10'd1023, 10'd1023, 9'd511, send_gap());
    // A new circle replaces a running one, taken while points are still going out.
    send_item(OP_START, 10'd512, 10'd300, 9'd1, send_gap());
    send_item(OP_STEP, 10'd0, 10'd0, 9'd0, send_gap());
    send_item(OP_START, 10'd5, 10'd7, 9'd2, 0);
    repeat (3) send_item(OP_STEP, 10'd0, 10'd0, 9'd0, send_gap());
    send_item(OP_START, 10'd1023, 10'd0, 9'd1, send_gap());
    repeat (2) send_item(OP_STEP, 10'd0, 10'd0, 9'd0, send_gap());
    send_item(OP_START, 10'd0, 10'd1023, 9'd256, send_gap());
    send_item(OP_STEP, 10'd0, 10'd0, 9'd0, send_gap());

    // Back-pressure: the result side holds off while steps and starts keep coming.
    squeeze_start <= 1'b1;
    send_item(OP_START, 10'($urandom), 10'($urandom), 9'd200, 0);
    repeat (4) send_item(OP_STEP, 10'($urandom), 10'($urandom), 9'($urandom), 0);
    send_item(OP_START, 10'($urandom), 10'($urandom), 9'd3, 0);
    repeat (4) send_item(OP_STEP, 10'($urandom), 10'($urandom), 9'($urandom), 0);

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      choice      = $urandom_range(0, 9);
      if (choice < 7) begin
        // Whole circle: mostly small radii run to completion, large ones partly.
        if ($urandom_range(0, 7) == 0) rad = 9'($urandom_range(0, 511));
        else rad = 9'($urandom_range(0, 12));
        send_item(OP_START, 10'($urandom), 10'($urandom), rad, send_gap());
        if (rad <= 12) nsteps = rad * 3 / 4 + 2 + $urandom_range(0, 1);
        else nsteps = $urandom_range(1, 4);
        repeat (nsteps)
          send_item(OP_STEP, 10'($urandom), 10'($urandom), 9'($urandom), send_gap());
      end else if (choice < 9) begin
        repeat ($urandom_range(1, 3))
          send_item(OP_STEP, 10'($urandom), 10'($urandom), 9'($urandom), send_gap());
      end else begin
        send_item(OP_START, 10'($urandom), 10'($urandom), 9'($urandom), send_gap());
      end
    end
    sender_calm = 1'b0;
    item_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    drain_check <= 1'b1;
    repeat (3) @(posedge clk);

    $display("Sent %0d transactions (%0d starts); checked %0d results, %0d finished markers.",
             sent, starts, points_checked, done_markers);
    $display("Covered zero and full radii, edge centres, restarts mid-circle, %0d-cycle stall.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("** midpoint_circle_rasterizer: PASSED **");
    end else begin
      $display("** midpoint_circle_rasterizer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("** midpoint_circle_rasterizer: FAILED **");
    $finish;
  end

endmodule
